// ----- hdl/swhs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package swhs_pkg;

	// Frame geometry
	localparam int FRAME_BITS = 40;
	localparam int BITS_W     = 6;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRANS  = 3'd4;

	// Register reset values
	localparam logic [15:0] RST_START_LOW  = 16'd18000;
	localparam logic [7:0]  RST_START_HIGH = 8'd40;
	localparam logic [7:0]  RST_ONE_THRESH = 8'd16;
	localparam logic [7:0]  RST_TIMEOUT    = 8'd255;
	localparam logic [6:0]  RST_MAX_TRANS  = 7'd85;

	// Status codes
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_CHECKSUM = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_LOW     = 2'd1,
		PH_HIGH    = 2'd2,
		PH_CAPTURE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  start_high_ticks;
		logic [7:0]  one_threshold;
		logic [7:0]  timeout_ticks;
		logic [6:0]  max_transitions;
	} cfg_t;

	// One classified transaction handed from front to back
	typedef struct packed {
		logic                  drive_enable;
		logic                  drive_level;
		logic                  done;
		logic                  frame_full;
		logic [FRAME_BITS-1:0] frame;
	} rec_t;

	// Queue write side
	typedef struct packed {
		logic push;
		rec_t rec;
	} qwr_t;

endpackage

`default_nettype wire

// ----- hdl/swhs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface swhs_in_if;
	logic valid;
	logic ready;
	logic func;
	logic line_level;

	modport source (output valid, output func, output line_level, input ready);
	modport sink   (input valid, input func, input line_level, output ready);
endinterface

interface swhs_out_if;
	logic               valid;
	logic               ready;
	logic               drive_enable;
	logic               drive_level;
	logic               done_res;
	logic [1:0]         status;
	logic [15:0]        humidity_tenths;
	logic signed [15:0] temperature_tenths;

	modport source (output valid, output drive_enable, output drive_level, output done_res,
		output status, output humidity_tenths, output temperature_tenths, input ready);
	modport sink   (input valid, input drive_enable, input drive_level, input done_res,
		input status, input humidity_tenths, input temperature_tenths, output ready);
endinterface

`default_nettype wire

// ----- hdl/swhs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swhs_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire swhs_pkg::cfg_t cfg,
	input  wire logic          q_full,
	output swhs_pkg::qwr_t     q_wr,
	swhs_in_if.sink            in_ch
);
	import swhs_pkg::*;

	phase_t                phase_q, phase_d;
	logic [15:0]           timer_q, timer_d, timer_inc;
	logic [7:0]            run_q, run_d, run_inc;
	logic                  prev_q, prev_d;
	logic [6:0]            ti_q, ti_d, ti_inc;
	logic [BITS_W-1:0]     bits_q, bits_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic                  fin;
	logic                  take;
	logic                  accept;

	assign in_ch.ready = ~q_full;
	assign accept      = in_ch.valid & ~q_full;

	assign timer_inc = timer_q + 16'd1;
	assign run_inc   = run_q + 8'd1;
	assign ti_inc    = ti_q + 7'd1;
	assign take      = (ti_q > 7'd3) && !ti_q[0] && (bits_q < BITS_W'(FRAME_BITS));

	// Next state of the sequencer and capture datapath
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		run_d   = run_q;
		prev_d  = prev_q;
		ti_d    = ti_q;
		bits_d  = bits_q;
		frame_d = frame_q;
		fin     = 1'b0;
		if (!in_ch.func) begin
			phase_d = PH_LOW;
			timer_d = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_LOW: begin
					if (timer_inc >= cfg.start_low_ticks || timer_inc == 16'd0) begin
						phase_d = PH_HIGH;
						timer_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_HIGH: begin
					if (timer_inc >= {8'd0, cfg.start_high_ticks}) begin
						phase_d = PH_CAPTURE;
						timer_d = '0;
						run_d   = '0;
						prev_d  = 1'b1;
						ti_d    = '0;
						bits_d  = '0;
						frame_d = '0;
					end else begin
						timer_d = timer_inc;
					end
				end
				PH_CAPTURE: begin
					if (in_ch.line_level == prev_q) begin
						run_d = run_inc;
						if (run_inc >= cfg.timeout_ticks) fin = 1'b1;
					end else begin
						// judge the closing high run
						if (take) begin
							frame_d = {frame_q[FRAME_BITS-2:0], (run_q > cfg.one_threshold)};
							bits_d  = bits_q + BITS_W'(1);
						end
						prev_d = in_ch.line_level;
						ti_d   = ti_inc;
						if (ti_inc >= cfg.max_transitions || ti_inc == 7'd0) begin
							fin = 1'b1;
						end else begin
							run_d = 8'd1;
							if (8'd1 >= cfg.timeout_ticks) fin = 1'b1;
						end
					end
					if (fin) phase_d = PH_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	// Classify the transaction for the back end
	always_comb begin
		q_wr.push             = accept;
		q_wr.rec.drive_enable = !in_ch.func || phase_q == PH_LOW || phase_q == PH_HIGH;
		q_wr.rec.drive_level  = in_ch.func && phase_q == PH_HIGH;
		q_wr.rec.done         = fin;
		q_wr.rec.frame_full   = (bits_d == BITS_W'(FRAME_BITS));
		q_wr.rec.frame        = frame_d;
	end

	// Advance state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			run_q   <= '0;
			prev_q  <= 1'b1;
			ti_q    <= '0;
			bits_q  <= '0;
			frame_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			run_q   <= run_d;
			prev_q  <= prev_d;
			ti_q    <= ti_d;
			bits_q  <= bits_d;
			frame_q <= frame_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/swhs_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swhs_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire swhs_pkg::qwr_t q_wr,
	input  wire logic          pop,
	output logic               full,
	output logic               empty,
	output swhs_pkg::rec_t     rd_rec
);
	import swhs_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full   = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty  = (count_q == '0);
	assign rd_rec = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (q_wr.push) mem_q[wr_ptr_q] <= q_wr.rec;
	end

	// Move pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)       rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({q_wr.push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/swhs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module swhs_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire swhs_pkg::rec_t rd_rec,
	input  wire logic          empty,
	output logic               pop,
	swhs_out_if.source         out_ch
);
	import swhs_pkg::*;

	logic [7:0]         b0, b1, b2, b3, b4, sum;
	logic [14:0]        mag;
	logic [1:0]         status_d;
	logic [15:0]        hum_d;
	logic [15:0]        temp_d;
	logic               valid_q;
	logic               de_q, dl_q, done_q;
	logic [1:0]         status_q;
	logic [15:0]        hum_q;
	logic signed [15:0] temp_q;

	assign b0  = rd_rec.frame[39:32];
	assign b1  = rd_rec.frame[31:24];
	assign b2  = rd_rec.frame[23:16];
	assign b3  = rd_rec.frame[15:8];
	assign b4  = rd_rec.frame[7:0];
	assign sum = b0 + b1 + b2 + b3;
	assign mag = {b2[6:0], b3};

	// Check the frame and decode readings
	always_comb begin
		status_d = ST_GOOD;
		hum_d    = '0;
		temp_d   = '0;
		if (rd_rec.done) begin
			priority if (!rd_rec.frame_full) begin
				status_d = ST_SHORT;
			end else if (sum != b4) begin
				status_d = ST_CHECKSUM;
			end else begin
				hum_d  = {b0, b1};
				temp_d = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
			end
		end
	end

	assign pop = !empty && (!valid_q || out_ch.ready);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ch.ready) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			de_q     <= rd_rec.drive_enable;
			dl_q     <= rd_rec.drive_level;
			done_q   <= rd_rec.done;
			status_q <= status_d;
			hum_q    <= hum_d;
			temp_q   <= signed'(temp_d);
		end
	end

	assign out_ch.valid              = valid_q;
	assign out_ch.drive_enable       = de_q;
	assign out_ch.drive_level        = dl_q;
	assign out_ch.done_res           = done_q;
	assign out_ch.status             = status_q;
	assign out_ch.humidity_tenths    = hum_q;
	assign out_ch.temperature_tenths = temp_q;

endmodule

`default_nettype wire

// ----- hdl/single_wire_humidity_sensor_reader.sv -----
// A transaction is written into the queue at the edge that accepts it; the back end pops it from there
// and registers its result in the output registers, where it stays until taken.
// Throughput: one transaction per cycle while the queue is not full (in_ch.ready is low when it is full);
// a two-entry queue decouples front and back.
// Reset (arst_n low, asynchronous): sequencer idle, queue empty, no result valid,
// configuration registers at their documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module single_wire_humidity_sensor_reader (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [swhs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swhs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	swhs_in_if.sink                            in_ch,
	swhs_out_if.source                         out_ch
);
	import swhs_pkg::*;

	cfg_t cfg_q;
	qwr_t q_wr;
	rec_t rd_rec;
	logic q_full;
	logic q_empty;
	logic q_pop;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks  <= RST_START_LOW;
			cfg_q.start_high_ticks <= RST_START_HIGH;
			cfg_q.one_threshold    <= RST_ONE_THRESH;
			cfg_q.timeout_ticks    <= RST_TIMEOUT;
			cfg_q.max_transitions  <= RST_MAX_TRANS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_LOW:  cfg_q.start_low_ticks  <= cfg_wdata;
				REG_START_HIGH: cfg_q.start_high_ticks <= cfg_wdata[7:0];
				REG_ONE_THRESH: cfg_q.one_threshold    <= cfg_wdata[7:0];
				REG_TIMEOUT:    cfg_q.timeout_ticks    <= cfg_wdata[7:0];
				REG_MAX_TRANS:  cfg_q.max_transitions  <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	swhs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_wr   (q_wr),
		.in_ch  (in_ch)
	);

	swhs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rd_rec (rd_rec)
	);

	swhs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_rec (rd_rec),
		.empty  (q_empty),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ----- verif/single_wire_humidity_sensor_reader_tb.sv -----
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_tb;
	import swhs_pkg::*;

	typedef struct packed {
		logic        drive_enable;
		logic        drive_level;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] humidity_tenths;
		logic [15:0] temperature_tenths;
	} sensor_out_t;

	typedef enum {RX_STREAM, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	localparam int ITEM_BUDGET = 1550;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	swhs_in_if  in_ch();
	swhs_out_if out_ch();

	single_wire_humidity_sensor_reader dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #4 clk = ~clk;

	// Sensor reader prediction state
	cfg_t                  sensor_cfg;
	phase_t                mdl_phase;
	logic [15:0]           mdl_timer;
	logic [7:0]            mdl_run;
	logic                  mdl_prev;
	logic [6:0]            mdl_trans;
	int                    mdl_bits;
	logic [FRAME_BITS-1:0] mdl_frame;

	sensor_out_t expected_outputs[$];
	int          mismatch_count = 0;
	int          sent_items = 0;
	int          rx_hold_cycles = 0;
	int          rx_stretch_left = 0;
	rx_mode_t    rx_mode = RX_STREAM;
	int          tx_burst_left = 0;

	function automatic logic rand_bit();
		return 1'($urandom());
	endfunction

	// Close a reading: check the frame and decode humidity and temperature
	function automatic sensor_out_t close_reading();
		sensor_out_t r;
		logic [7:0]  b0, b1, b2, b3, b4;
		logic [15:0] mag;
		r = '0;
		r.done_res = 1'b1;
		{b0, b1, b2, b3, b4} = mdl_frame;
		if (mdl_bits < FRAME_BITS) begin
			r.status = ST_SHORT;
		end else if (8'(b0 + b1 + b2 + b3) != b4) begin
			r.status = ST_CHECKSUM;
		end else begin
			r.status = ST_GOOD;
			r.humidity_tenths = {b0, b1};
			mag = {1'b0, b2[6:0], b3};
			r.temperature_tenths = b2[7] ? 16'd0 - mag : mag;
		end
		mdl_phase = PH_IDLE;
		return r;
	endfunction

	// Advance the sensor reader by one transaction and return its outputs
	function automatic sensor_out_t predict_output(logic f, logic lvl);
		sensor_out_t r;
		r = '0;
		if (!f) begin
			mdl_phase = PH_LOW;
			mdl_timer = '0;
			r.drive_enable = 1'b1;
			return r;
		end
		case (mdl_phase)
			PH_LOW: begin
				r.drive_enable = 1'b1;
				mdl_timer++;
				if (mdl_timer >= sensor_cfg.start_low_ticks || mdl_timer == 0) begin
					mdl_phase = PH_HIGH;
					mdl_timer = '0;
				end
			end
			PH_HIGH: begin
				r.drive_enable = 1'b1;
				r.drive_level = 1'b1;
				mdl_timer++;
				if (mdl_timer >= {8'd0, sensor_cfg.start_high_ticks}) begin
					mdl_phase = PH_CAPTURE;
					mdl_timer = '0;
					mdl_run = '0;
					mdl_prev = 1'b1;
					mdl_trans = '0;
					mdl_bits = 0;
					mdl_frame = '0;
				end
			end
			PH_CAPTURE: begin
				if (lvl == mdl_prev) begin
					mdl_run++;
					if (mdl_run >= sensor_cfg.timeout_ticks)
						r = close_reading();
				end else begin
					// Judge the closing high run on even transitions past the preamble
					if (mdl_trans > 7'd3 && !mdl_trans[0] && mdl_bits < FRAME_BITS) begin
						mdl_frame = {mdl_frame[FRAME_BITS-2:0],
							mdl_run > sensor_cfg.one_threshold};
						mdl_bits++;
					end
					mdl_prev = lvl;
					mdl_trans++;
					if (mdl_trans >= sensor_cfg.max_transitions || mdl_trans == 0) begin
						r = close_reading();
					end else begin
						mdl_run = 8'd1;
						if (mdl_run >= sensor_cfg.timeout_ticks)
							r = close_reading();
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Offer one transaction in bursts with random gaps; predict it on acceptance
	task automatic send_item(logic f, logic lvl);
		int gap;
		if (tx_burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? $urandom_range(8, 1) : 0;
			repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
			tx_burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
				: $urandom_range(30, 1);
		end
		tx_burst_left--;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.func <= f;
		in_ch.line_level <= lvl;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent_items++;
		expected_outputs.push_back(predict_output(f, lvl));
	endtask

	// Hold the input and wait until every result is back
	task automatic wait_drained();
		@(negedge clk) in_ch.valid <= 1'b0;
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		logic [CFG_DATA_W-1:0] data;
		logic [CFG_DATA_W-1:0] junk;
		int                    width;
		wait_drained();
		width = CFG_DATA_W;
		case (idx)
			REG_START_LOW:  sensor_cfg.start_low_ticks = 16'(value);
			REG_START_HIGH: begin
				sensor_cfg.start_high_ticks = 8'(value);
				width = 8;
			end
			REG_ONE_THRESH: begin
				sensor_cfg.one_threshold = 8'(value);
				width = 8;
			end
			REG_TIMEOUT: begin
				sensor_cfg.timeout_ticks = 8'(value);
				width = 8;
			end
			REG_MAX_TRANS: begin
				sensor_cfg.max_transitions = 7'(value);
				width = 7;
			end
			default: ;
		endcase
		data = CFG_DATA_W'(value);
		// Put junk above narrow registers now and then
		if (width < CFG_DATA_W && $urandom_range(3, 0) == 0) begin
			junk = CFG_DATA_W'($urandom());
			data = data | (junk << width);
		end
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic set_config(int low, int high, int thr, int tmo, int mt);
		write_reg(REG_START_LOW, low);
		write_reg(REG_START_HIGH, high);
		write_reg(REG_ONE_THRESH, thr);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_MAX_TRANS, mt);
	endtask

	// Run length in [lo, hi], kept short of the timeout where possible
	function automatic int pick_len(int lo, int hi);
		int top;
		top = hi;
		if (top > int'(sensor_cfg.timeout_ticks) - 1)
			top = int'(sensor_cfg.timeout_ticks) - 1;
		if (top < lo)
			top = lo;
		return $urandom_range(top, lo);
	endfunction

	function automatic logic [FRAME_BITS-1:0] make_frame(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3, bit good);
		logic [7:0] sum;
		sum = b0 + b1 + b2 + b3;
		if (!good)
			sum = sum ^ 8'($urandom_range(255, 1));
		return {b0, b1, b2, b3, sum};
	endfunction

	function automatic logic [FRAME_BITS-1:0] random_frame();
		return make_frame(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
			$urandom_range(4, 0) != 0);
	endfunction

	task automatic send_run(logic lvl, int n);
		repeat (n) send_item(1'b1, lvl);
	endtask

	// Start pulse, sensor preamble, nbits data bits, closing low and idle-high tail
	task automatic send_reading(logic [FRAME_BITS-1:0] frame, int nbits);
		int   k;
		int   thr;
		logic b;
		thr = int'(sensor_cfg.one_threshold);
		send_item(1'b0, rand_bit());
		repeat (int'(sensor_cfg.start_low_ticks) + int'(sensor_cfg.start_high_ticks))
			send_item(1'b1, rand_bit());
		send_run(1'b1, pick_len(0, 2));
		send_run(1'b0, pick_len(1, 2));
		send_run(1'b1, pick_len(1, 2));
		for (k = 0; k < nbits; k++) begin
			b = (k < FRAME_BITS) ? frame[FRAME_BITS-1-k] : rand_bit();
			send_run(1'b0, pick_len(1, 2));
			send_run(1'b1, b ? pick_len(thr + 1, thr + 2) : pick_len(1, thr));
		end
		send_run(1'b0, pick_len(1, 2));
		send_run(1'b1, int'(sensor_cfg.timeout_ticks));
	endtask

	// Random line activity with occasional restarts
	task automatic send_noise();
		int   count;
		int   i;
		logic lvl;
		send_item(1'b0, rand_bit());
		count = $urandom_range(60, 10);
		lvl = 1'b1;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(40, 0) == 0) begin
				send_item(1'b0, rand_bit());
			end else begin
				if ($urandom_range(2, 0) == 0)
					lvl = ~lvl;
				send_item(1'b1, lvl);
			end
		end
	endtask

	task automatic test_reset_defaults();
		// shorten the start pulse; every other register keeps its reset value
		write_reg(REG_START_LOW, 2);
		send_reading(make_frame(8'h02, 8'h8C, 8'h01, 8'h5F, 1'b1), 2);
		wait_drained();
	endtask

	task automatic test_idle_and_restart();
		set_config(3, 2, 1, 12, 85);
		send_item(1'b1, 1'b0);
		send_item(1'b1, 1'b1);
		repeat (4) send_item(1'b1, rand_bit());
		// restart inside the low pulse
		send_item(1'b0, 1'b1);
		send_item(1'b1, 1'b0);
		send_item(1'b0, 1'b0);
		// restart inside the high pulse
		repeat (4) send_item(1'b1, 1'b1);
		send_item(1'b0, 1'b1);
		// restart inside capture
		repeat (5) send_item(1'b1, 1'b0);
		send_run(1'b0, 3);
		send_run(1'b1, 3);
		send_run(1'b0, 2);
		send_reading(make_frame(8'h01, 8'hF4, 8'h00, 8'hE6, 1'b1), 12);
		repeat (4) send_item(1'b1, rand_bit());
		wait_drained();
	endtask

	task automatic test_frame_values();
		set_config(1, 1, 1, 4, 85);
		send_reading(make_frame(8'h12, 8'h34, 8'hFF, 8'hFF, 1'b1), FRAME_BITS);
		send_reading(random_frame(), 0);
		wait_drained();
	endtask

	task automatic test_transition_limits();
		// transition count ends the reading on its limit
		set_config(1, 1, 1, 4, 84);
		send_reading(random_frame(), FRAME_BITS);
		set_config(1, 1, 1, 4, 1);
		send_reading(random_frame(), 0);
		// shortest timeout, zero threshold
		set_config(1, 1, 1, 1, 85);
		send_reading(random_frame(), 0);
		set_config(1, 1, 0, 2, 85);
		send_reading(random_frame(), 3);
		// bits past the frame are timed but dropped
		set_config(1, 1, 1, 4, 127);
		send_reading(random_frame(), FRAME_BITS + 2);
		wait_drained();
	endtask

	task automatic test_long_start_pulse();
		// start count above the 8-bit range
		set_config(257, 1, 1, 4, 85);
		send_reading(random_frame(), 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		set_config(2, 2, 1, 4, 85);
		rx_hold_cycles = 400;
		send_reading(random_frame(), 8);
		wait_drained();
	endtask

	task automatic random_config();
		int low, high, thr, tmo, mt;
		low = ($urandom_range(9, 0) < 8) ? $urandom_range(4, 1) : $urandom_range(40, 5);
		high = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 5) : $urandom_range(4, 1);
		thr = $urandom_range(4, 0);
		case ($urandom_range(5, 0))
			0:       tmo = $urandom_range(30, 16);
			1:       tmo = $urandom_range(3, 1);
			default: tmo = thr + $urandom_range(6, 2);
		endcase
		case ($urandom_range(5, 0))
			0:       mt = $urandom_range(127, 1);
			1:       mt = 83 + $urandom_range(3, 0);
			default: mt = 85;
		endcase
		set_config(low, high, thr, tmo, mt);
	endtask

	task automatic test_random_readings();
		int kind;
		while (sent_items < ITEM_BUDGET) begin
			random_config();
			repeat ($urandom_range(4, 1)) begin
				if (sent_items < ITEM_BUDGET) begin
					kind = $urandom_range(9, 0);
					if (kind < 6)
						send_reading(random_frame(), FRAME_BITS);
					else if (kind == 6)
						send_reading(random_frame(), $urandom_range(FRAME_BITS - 1, 0));
					else if (kind == 7)
						send_reading(random_frame(), $urandom_range(62, FRAME_BITS + 1));
					else
						send_noise();
					if ($urandom_range(3, 0) == 0)
						repeat ($urandom_range(5, 1)) send_item(1'b1, rand_bit());
				end
			end
		end
		wait_drained();
	endtask

	// Stall the result side on a changing pattern, or hold it off on request
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_ch.ready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			if (rx_stretch_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(3, 0));
				rx_stretch_left = $urandom_range(200, 10);
			end
			rx_stretch_left--;
			case (rx_mode)
				RX_STREAM:   out_ch.ready <= 1'b1;
				RX_COIN:     out_ch.ready <= 1'($urandom_range(1, 0));
				RX_MOSTLY:   out_ch.ready <= ($urandom_range(7, 0) != 0);
				default:     out_ch.ready <= (rx_stretch_left % 5) != 0;
			endcase
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		sensor_out_t got;
		sensor_out_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = {out_ch.drive_enable, out_ch.drive_level, out_ch.done_res, out_ch.status,
				out_ch.humidity_tenths, out_ch.temperature_tenths};
			if (expected_outputs.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: result with nothing outstanding: de=%0b dl=%0b done=%0b",
						$realtime, got.drive_enable, got.drive_level, got.done_res);
				mismatch_count++;
			end else begin
				want = expected_outputs.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10) begin
						$display("%0t: mismatch exp de=%0b dl=%0b done=%0b st=%0d hum=%0d temp=%0d",
							$realtime, want.drive_enable, want.drive_level, want.done_res,
							want.status, want.humidity_tenths,
							$signed(want.temperature_tenths));
						$display("%0t:          got de=%0b dl=%0b done=%0b st=%0d hum=%0d temp=%0d",
							$realtime, got.drive_enable, got.drive_level, got.done_res,
							got.status, got.humidity_tenths,
							$signed(got.temperature_tenths));
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#1_000_000;
		$display("[single_wire_humidity_sensor_reader] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.line_level = 1'b0;
		out_ch.ready = 1'b0;
		sensor_cfg = '{start_low_ticks: RST_START_LOW, start_high_ticks: RST_START_HIGH,
			one_threshold: RST_ONE_THRESH, timeout_ticks: RST_TIMEOUT,
			max_transitions: RST_MAX_TRANS};
		mdl_phase = PH_IDLE;
		mdl_timer = '0;
		mdl_run = '0;
		mdl_prev = 1'b1;
		mdl_trans = '0;
		mdl_bits = 0;
		mdl_frame = '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_defaults();
		test_idle_and_restart();
		test_frame_values();
		test_transition_limits();
		test_long_start_pulse();
		test_backpressure();
		test_random_readings();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[single_wire_humidity_sensor_reader] OK");
		else
			$display("[single_wire_humidity_sensor_reader] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/swhs_pkg.sv
hdl/swhs_if.sv
hdl/swhs_front.sv
hdl/swhs_fifo.sv
hdl/swhs_back.sv
hdl/single_wire_humidity_sensor_reader.sv
verif/single_wire_humidity_sensor_reader_tb.sv
